// File: rtl/nnr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and the queue control type of the
// nearest-neighbor resizer. No dependencies.

package nnr_pkg;

   // Fixed field widths of the external channels and the register port
   localparam int PIX_W     = 16;
   localparam int CFG_W     = 9;
   localparam int CFG_CH_W  = 3;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT       = 3'd5;

   // Request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EMIT = 1'b1;

   // Defaults of the top-level parameters
   localparam int DEF_MAX_DIM      = 256;
   localparam int DEF_MAX_CHANNELS = 4;
   localparam int DEF_PIXEL_BITS   = 16;

   // Depth of the command queue and of the result queue
   localparam int QUEUE_DEPTH = 2;

   // Control part of one queued store command
   typedef struct packed {
      logic rd;     // 1: read for a result word, 0: write a loaded pixel
      logic last;   // final pixel of the destination frame
   } nnr_ctl_type;

endpackage

// File: rtl/nnr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the resizer: request and response.
// Depends on nnr_pkg.

interface nnr_req_if;
   import nnr_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output action, output pixel_in, input ready);
   modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface nnr_rsp_if;
   import nnr_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// File: rtl/nnr_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the scale steps.
// Depends on nnr_pkg only by convention; no package items are used.

module nnr_div #(
   parameter int W = 9,
   localparam int CNT_W = $clog2(W + 1)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         busy,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]       trial;

   // The top bit of the trial difference is set when the divisor did not fit.
   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = (cnt_ff != '0);
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/nnr_queue.sv
`timescale 1ns / 1ps
// Small register FIFO used as the command queue and the result queue.
// Depends on nnr_pkg for the default depth.

module nnr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nnr_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data,
   output logic [CNT_W-1:0] level
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff < CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/nnr_front.sv
`timescale 1ns / 1ps
// Front end: register file, scale setup and address generation for loads
// and for destination pixels. Depends on nnr_pkg, nnr_if and nnr_div.

module nnr_front #(
   parameter int MAX_DIM      = nnr_pkg::DEF_MAX_DIM,
   parameter int MAX_CHANNELS = nnr_pkg::DEF_MAX_CHANNELS,
   parameter int PIXEL_BITS   = nnr_pkg::DEF_PIXEL_BITS,
   localparam int AW = $clog2(MAX_CHANNELS * MAX_DIM * MAX_DIM)
) (
   input  logic                           clock,
   input  logic                           reset,
   nnr_req_if.sink                        req,
   input  logic                           csr_we,
   input  logic [nnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnr_pkg::CFG_W-1:0]      csr_wdata,
   output logic                           q_valid,
   input  logic                           q_ready,
   output nnr_pkg::nnr_ctl_type           q_ctl,
   output logic [AW-1:0]                  q_addr,
   output logic [PIXEL_BITS-1:0]          q_data
);
   import nnr_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CRD_W = $clog2(MAX_DIM);
   localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RW    = DIM_W + 1;
   localparam int SW2   = DIM_W + 2;
   localparam int PW    = 2 * DIM_W;

   localparam logic [1:0] ST_DIV_GO   = 2'd0;
   localparam logic [1:0] ST_DIV_WAIT = 2'd1;
   localparam logic [1:0] ST_MUL      = 2'd2;
   localparam logic [1:0] ST_RUN      = 2'd3;

   function automatic int unsigned clamp_cfg(int unsigned raw, int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [CFG_W-1:0]    sw_raw_ff, sh_raw_ff, dw_raw_ff, dh_raw_ff;
   logic [CFG_CH_W-1:0] ch_raw_ff;

   logic [DIM_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
   logic [CH_W-1:0]  ch_eff;
   logic             cfg_hit;
   logic             accept;
   logic             div_start;
   logic             busy_x, busy_y;
   logic [DIM_W-1:0] ax, mx, ay, my;

   // Destination position and its source-side stepping state
   logic [CRD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CI_W-1:0]  chan_ff, chan_in;
   logic [CRD_W-1:0] qx_ff, qx_in;
   logic [RW-1:0]    rx_ff, rx_in, ry_ff, ry_in;
   logic [AW-1:0]    row_addr_ff, row_addr_in;
   logic [AW-1:0]    plane_base_ff, plane_base_in;
   logic [AW-1:0]    plane_ff, plane_in;
   logic [AW-1:0]    ay_sw_ff, ay_sw_in;
   logic [AW-1:0]    y0_sw_ff, y0_sw_in;

   // Load position
   logic [CRD_W-1:0] lcol_ff, lcol_in, lrow_ff, lrow_in;
   logic [CI_W-1:0]  lchan_ff, lchan_in;
   logic [AW-1:0]    laddr_ff, laddr_in;

   logic [CRD_W-1:0] qx0;
   logic [RW-1:0]    rx0, ry0, dx2, dy2, bx, by;
   logic [SW2-1:0]   sx_sum, sy_sum;
   logic             cx, cy;
   logic [RW-1:0]    rx_step, ry_step;
   logic [CRD_W-1:0] qx_step;
   logic [AW-1:0]    y0_prod;
   logic             col_last, row_last, chan_last;
   logic             lcol_last, lrow_last, lchan_last;

   assign sw_eff = DIM_W'(clamp_cfg(32'(sw_raw_ff), MAX_DIM));
   assign sh_eff = DIM_W'(clamp_cfg(32'(sh_raw_ff), MAX_DIM));
   assign dw_eff = DIM_W'(clamp_cfg(32'(dw_raw_ff), MAX_DIM));
   assign dh_eff = DIM_W'(clamp_cfg(32'(dh_raw_ff), MAX_DIM));
   assign ch_eff = CH_W'(clamp_cfg(32'(ch_raw_ff), MAX_CHANNELS));

   assign cfg_hit   = csr_we && (csr_index < CSR_COUNT);
   assign div_start = (state_ff == ST_DIV_GO);

   // src = a*dst + m for each axis; a and m drive the incremental mapping.
   nnr_div #(.W(DIM_W)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sw_eff),
      .den   (dw_eff),
      .busy  (busy_x),
      .quo   (ax),
      .rem   (mx)
   );

   nnr_div #(.W(DIM_W)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sh_eff),
      .den   (dh_eff),
      .busy  (busy_y),
      .quo   (ay),
      .rem   (my)
   );

   // Column k maps to floor(src*(2k+1) / (2*dst)). The quotient and remainder
   // advance by a and 2m per step, with one carry when the remainder overflows.
   assign dx2     = {dw_eff, 1'b0};
   assign dy2     = {dh_eff, 1'b0};
   assign bx      = {mx, 1'b0};
   assign by      = {my, 1'b0};
   assign qx0     = CRD_W'(ax >> 1);
   assign rx0     = (ax[0] ? RW'(dw_eff) : '0) + RW'(mx);
   assign ry0     = (ay[0] ? RW'(dh_eff) : '0) + RW'(my);
   assign sx_sum  = SW2'(rx_ff) + SW2'(bx);
   assign sy_sum  = SW2'(ry_ff) + SW2'(by);
   assign cx      = (sx_sum >= SW2'(dx2));
   assign cy      = (sy_sum >= SW2'(dy2));
   assign rx_step = RW'(cx ? sx_sum - SW2'(dx2) : sx_sum);
   assign ry_step = RW'(cy ? sy_sum - SW2'(dy2) : sy_sum);
   assign qx_step = qx_ff + CRD_W'(ax) + CRD_W'(cx);
   assign y0_prod = AW'(PW'(ay >> 1) * PW'(sw_eff));

   assign col_last   = (DIM_W'(col_ff) + DIM_W'(1)) == dw_eff;
   assign row_last   = (DIM_W'(row_ff) + DIM_W'(1)) == dh_eff;
   assign chan_last  = (CH_W'(chan_ff) + CH_W'(1)) == ch_eff;
   assign lcol_last  = (DIM_W'(lcol_ff) + DIM_W'(1)) == sw_eff;
   assign lrow_last  = (DIM_W'(lrow_ff) + DIM_W'(1)) == sh_eff;
   assign lchan_last = (CH_W'(lchan_ff) + CH_W'(1)) == ch_eff;

   assign req.ready = (state_ff == ST_RUN) && q_ready;
   assign accept    = req.valid && req.ready;

   assign q_valid    = accept;
   assign q_ctl.rd   = (req.action == ACT_EMIT);
   assign q_ctl.last = col_last && row_last && chan_last;
   assign q_addr     = (req.action == ACT_EMIT) ? row_addr_ff + AW'(qx_ff) : laddr_ff;
   assign q_data     = PIXEL_BITS'(req.pixel_in);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (!busy_x && !busy_y) state_in = ST_MUL;
         ST_MUL:      state_in = ST_RUN;
         ST_RUN:      state_in = ST_RUN;
         default:     state_in = ST_DIV_GO;
      endcase
      if (cfg_hit) begin
         state_in = ST_DIV_GO;
      end
   end

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      chan_in       = chan_ff;
      qx_in         = qx_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      row_addr_in   = row_addr_ff;
      plane_base_in = plane_base_ff;
      plane_in      = plane_ff;
      ay_sw_in      = ay_sw_ff;
      y0_sw_in      = y0_sw_ff;
      lcol_in       = lcol_ff;
      lrow_in       = lrow_ff;
      lchan_in      = lchan_ff;
      laddr_in      = laddr_ff;
      if (state_ff == ST_MUL) begin
         plane_in      = AW'(PW'(sh_eff) * PW'(sw_eff));
         ay_sw_in      = AW'(PW'(ay) * PW'(sw_eff));
         y0_sw_in      = y0_prod;
         row_addr_in   = y0_prod;
         plane_base_in = '0;
         col_in        = '0;
         row_in        = '0;
         chan_in       = '0;
         qx_in         = qx0;
         rx_in         = rx0;
         ry_in         = ry0;
         lcol_in       = '0;
         lrow_in       = '0;
         lchan_in      = '0;
         laddr_in      = '0;
      end else if (accept && (req.action == ACT_LOAD)) begin
         if (lcol_last) begin
            lcol_in = '0;
            if (lrow_last) begin
               lrow_in  = '0;
               lchan_in = lchan_last ? '0 : lchan_ff + CI_W'(1);
            end else begin
               lrow_in = lrow_ff + CRD_W'(1);
            end
         end else begin
            lcol_in = lcol_ff + CRD_W'(1);
         end
         laddr_in = (lcol_last && lrow_last && lchan_last) ? '0 : laddr_ff + AW'(1);
      end else if (accept) begin
         if (!col_last) begin
            col_in = col_ff + CRD_W'(1);
            qx_in  = qx_step;
            rx_in  = rx_step;
         end else begin
            col_in = '0;
            qx_in  = qx0;
            rx_in  = rx0;
            if (!row_last) begin
               row_in      = row_ff + CRD_W'(1);
               ry_in       = ry_step;
               row_addr_in = row_addr_ff + ay_sw_ff + (cy ? AW'(sw_eff) : '0);
            end else begin
               row_in = '0;
               ry_in  = ry0;
               if (!chan_last) begin
                  chan_in       = chan_ff + CI_W'(1);
                  plane_base_in = plane_base_ff + plane_ff;
                  row_addr_in   = plane_base_ff + plane_ff + y0_sw_ff;
               end else begin
                  chan_in       = '0;
                  plane_base_in = '0;
                  row_addr_in   = y0_sw_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_DIV_GO;
         sw_raw_ff     <= CFG_W'(1);
         sh_raw_ff     <= CFG_W'(1);
         ch_raw_ff     <= CFG_CH_W'(1);
         dw_raw_ff     <= CFG_W'(1);
         dh_raw_ff     <= CFG_W'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         chan_ff       <= '0;
         plane_base_ff <= '0;
         lcol_ff       <= '0;
         lrow_ff       <= '0;
         lchan_ff      <= '0;
         laddr_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         chan_ff       <= chan_in;
         plane_base_ff <= plane_base_in;
         lcol_ff       <= lcol_in;
         lrow_ff       <= lrow_in;
         lchan_ff      <= lchan_in;
         laddr_ff      <= laddr_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  sw_raw_ff <= csr_wdata;
               CSR_SRC_HEIGHT: sh_raw_ff <= csr_wdata;
               CSR_CHANNELS:   ch_raw_ff <= csr_wdata[CFG_CH_W-1:0];
               CSR_DST_WIDTH:  dw_raw_ff <= csr_wdata;
               CSR_DST_HEIGHT: dh_raw_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      qx_ff       <= qx_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      row_addr_ff <= row_addr_in;
      plane_ff    <= plane_in;
      ay_sw_ff    <= ay_sw_in;
      y0_sw_ff    <= y0_sw_in;
   end

endmodule

// File: rtl/nnr_back.sv
`timescale 1ns / 1ps
// Back end: single-port frame store, registered read and result queue.
// Depends on nnr_pkg, nnr_if and nnr_queue.

module nnr_back #(
   parameter int MAX_DIM      = nnr_pkg::DEF_MAX_DIM,
   parameter int MAX_CHANNELS = nnr_pkg::DEF_MAX_CHANNELS,
   parameter int PIXEL_BITS   = nnr_pkg::DEF_PIXEL_BITS,
   localparam int AW = $clog2(MAX_CHANNELS * MAX_DIM * MAX_DIM)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  nnr_pkg::nnr_ctl_type  q_ctl,
   input  logic [AW-1:0]         q_addr,
   input  logic [PIXEL_BITS-1:0] q_data,
   nnr_rsp_if.source             rsp
);
   import nnr_pkg::*;

   localparam int DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W = LVL_W + 1;

   logic [PIXEL_BITS-1:0] store_mem [DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  pop;
   logic                  room;
   logic                  oq_deq;
   logic [LVL_W-1:0]      oq_level;
   logic [PIX_W:0]        oq_in;
   logic [PIX_W:0]        oq_out;

   // A read may issue only when its word is sure of a result queue slot,
   // counting the read still in flight.
   assign oq_deq  = rsp.valid && rsp.ready;
   assign room    = (OCC_W'(s1_valid_ff) + OCC_W'(oq_level))
                    < (OCC_W'(QUEUE_DEPTH) + OCC_W'(oq_deq));
   assign q_ready = !q_ctl.rd || room;
   assign pop     = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (pop && !q_ctl.rd) begin
         store_mem[q_addr] <= q_data;
      end
      rd_data_ff <= store_mem[q_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop && q_ctl.rd;
      end
      s1_last_ff <= q_ctl.last;
   end

   assign oq_in = {s1_last_ff, PIX_W'(rd_data_ff)};

   nnr_queue #(.WIDTH(PIX_W + 1), .DEPTH(QUEUE_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (),
      .in_data   (oq_in),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (oq_out),
      .level     (oq_level)
   );

   assign rsp.frame_last = oq_out[PIX_W];
   assign rsp.pixel_out  = oq_out[PIX_W-1:0];

endmodule

// File: rtl/nearest_neighbor_resize.sv
`timescale 1ns / 1ps
// Top level of the nearest-neighbor resizer: front end, command queue and
// back end. Depends on nnr_pkg, nnr_if, nnr_front, nnr_queue and nnr_back.
//
//   Port     Dir  Moves
//   req_ch   in   one word: action (load or emit) and pixel_in
//   rsp_ch   out  one word per emit: pixel_out and frame_last
//   csr_*    in   register write: csr_we, csr_index, csr_wdata
//
// In steady operation one request word is taken per cycle; the single port
// of the frame store, shared by loads and reads, sets that rate.
// An emit passes the command queue, read register and result queue.
// After reset and after each register write, req_ch.ready stays low while
// the setup runs: one divider start, the divider steps, a state that sees the
// dividers done and one multiply state.
// A stalled rsp_ch fills the two-word result queue and then the two-word
// command queue, after which req_ch.ready drops.

module nearest_neighbor_resize #(
   parameter int MAX_DIM      = nnr_pkg::DEF_MAX_DIM,
   parameter int MAX_CHANNELS = nnr_pkg::DEF_MAX_CHANNELS,
   parameter int PIXEL_BITS   = nnr_pkg::DEF_PIXEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   nnr_req_if.sink                       req_ch,
   nnr_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [nnr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnr_pkg::CFG_W-1:0]     csr_wdata
);
   import nnr_pkg::*;

   localparam int AW    = $clog2(MAX_CHANNELS * MAX_DIM * MAX_DIM);
   localparam int CTL_W = $bits(nnr_ctl_type);
   localparam int QW    = CTL_W + AW + PIXEL_BITS;

   logic                  fq_in_valid, fq_in_ready;
   nnr_ctl_type           fq_in_ctl;
   logic [AW-1:0]         fq_in_addr;
   logic [PIXEL_BITS-1:0] fq_in_data;
   logic                  fq_out_valid, fq_out_ready;
   nnr_ctl_type           fq_out_ctl;
   logic [AW-1:0]         fq_out_addr;
   logic [PIXEL_BITS-1:0] fq_out_data;
   logic [QW-1:0]         fq_in_word, fq_out_word;

   nnr_front #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS),
      .PIXEL_BITS   (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (fq_in_valid),
      .q_ready   (fq_in_ready),
      .q_ctl     (fq_in_ctl),
      .q_addr    (fq_in_addr),
      .q_data    (fq_in_data)
   );

   assign fq_in_word = {fq_in_ctl, fq_in_addr, fq_in_data};

   nnr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_in_valid),
      .in_ready  (fq_in_ready),
      .in_data   (fq_in_word),
      .out_valid (fq_out_valid),
      .out_ready (fq_out_ready),
      .out_data  (fq_out_word),
      .level     ()
   );

   assign {fq_out_ctl, fq_out_addr, fq_out_data} = fq_out_word;

   nnr_back #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS),
      .PIXEL_BITS   (PIXEL_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (fq_out_valid),
      .q_ready (fq_out_ready),
      .q_ctl   (fq_out_ctl),
      .q_addr  (fq_out_addr),
      .q_data  (fq_out_data),
      .rsp     (rsp_ch)
   );

endmodule

// File: rtl/nnr_check.sv
`timescale 1ns / 1ps
// Port-level checks of the resizer and the bind that attaches them.
// Depends on nnr_pkg and nearest_neighbor_resize.

module nnr_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [nnr_pkg::PIX_W-1:0]     rsp_pixel_out,
   input logic                          rsp_frame_last,
   input logic                          csr_we,
   input logic [nnr_pkg::CSR_IDX_W-1:0] csr_index
);
   import nnr_pkg::*;

   // A stalled result word stays and keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
                                  && $stable(rsp_frame_last))
      else $error("result word changed while stalled");

   // A register write restarts the setup, so no request is taken next cycle.
   a_cfg_setup: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index < CSR_COUNT) |=> !req_ready)
      else $error("request taken right after a register write");

   // Reset empties the queues and starts the setup.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

   // No request word is taken while its valid is low.
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid |-> !(req_valid && req_ready))
      else $error("request accepted without valid");

endmodule

bind nearest_neighbor_resize nnr_check u_nnr_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pixel_out  (rsp_ch.pixel_out),
   .rsp_frame_last (rsp_ch.frame_last),
   .csr_we         (csr_we),
   .csr_index      (csr_index)
);

// File: tb/nnr_resize_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the nearest-neighbor resizer testbench: watches the request,
// response and register ports, predicts every result word and compares it.
// Depends on nnr_pkg and nnr_if.

module nnr_resize_checker (
   input  logic                          clock,
   input  logic                          reset,
   nnr_req_if                            req_mon,
   nnr_rsp_if                            rsp_mon,
   input  logic                          csr_we,
   input  logic [nnr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnr_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            words_pending,
   output int                            results_checked,
   output int                            frames_seen
);
   import nnr_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } resize_word_type;

   logic [CFG_W-1:0] reg_raw [CSR_COUNT];
   logic [PIX_W-1:0] frame_mem [int unsigned];
   resize_word_type  pixel_queue [$];
   int unsigned      load_pos, col_pos, row_pos, chan_pos;

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                              input int unsigned hi);
      if (raw == '0) return 1;
      if (raw > hi) return hi;
      return 32'(raw);
   endfunction

   // Center-aligned nearest source index: (k + 0.5) * src / dst - 0.5,
   // rounded half up and clamped, done exactly in integers.
   function automatic int unsigned nearest_source(input int unsigned k,
                                                  input int unsigned src,
                                                  input int unsigned dst);
      int unsigned q;
      q = (src * (2 * k + 1)) / (2 * dst);
      return (q > src - 1) ? src - 1 : q;
   endfunction

   always @(posedge clock) begin : watch
      int unsigned     sw, sh, ch, dw, dh, sx, sy, c, addr;
      resize_word_type exp_word;
      if (reset) begin
         foreach (reg_raw[i]) reg_raw[i] = CFG_W'(1);
         load_pos = 0;
         col_pos  = 0;
         row_pos  = 0;
         chan_pos = 0;
         pixel_queue.delete();
         frame_mem.delete();
      end else begin
         // Any write to a real register restarts both the load and the output scan.
         if (csr_we && csr_index < CSR_COUNT) begin
            if (csr_index == CSR_CHANNELS)
               reg_raw[csr_index] = CFG_W'(csr_wdata[CFG_CH_W-1:0]);
            else
               reg_raw[csr_index] = csr_wdata;
            load_pos = 0;
            col_pos  = 0;
            row_pos  = 0;
            chan_pos = 0;
         end
         sw = clamp_size(reg_raw[CSR_SRC_WIDTH], DEF_MAX_DIM);
         sh = clamp_size(reg_raw[CSR_SRC_HEIGHT], DEF_MAX_DIM);
         ch = clamp_size(reg_raw[CSR_CHANNELS], DEF_MAX_CHANNELS);
         dw = clamp_size(reg_raw[CSR_DST_WIDTH], DEF_MAX_DIM);
         dh = clamp_size(reg_raw[CSR_DST_HEIGHT], DEF_MAX_DIM);

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_LOAD) begin
               frame_mem[load_pos] = req_mon.pixel_in;
               load_pos++;
               if (load_pos >= ch * sh * sw) load_pos = 0;
            end else begin
               sx   = nearest_source(col_pos, sw, dw);
               sy   = nearest_source(row_pos, sh, dh);
               c    = (chan_pos < ch) ? chan_pos : ch - 1;
               addr = c * sh * sw + sy * sw + sx;
               exp_word.pixel = frame_mem.exists(addr) ? frame_mem[addr] : '0;
               exp_word.last  = (chan_pos + 1 >= ch) && (row_pos + 1 >= dh) &&
                                (col_pos + 1 >= dw);
               pixel_queue.push_back(exp_word);
               col_pos++;
               if (col_pos >= dw) begin
                  col_pos = 0;
                  row_pos++;
                  if (row_pos >= dh) begin
                     row_pos = 0;
                     chan_pos++;
                     if (chan_pos >= ch) chan_pos = 0;
                  end
               end
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result word with none expected: pixel_out=%h frame_last=%b",
                           $time, rsp_mon.pixel_out, rsp_mon.frame_last);
            end else begin
               exp_word = pixel_queue.pop_front();
               results_checked++;
               if (exp_word.last) frames_seen++;
               if (rsp_mon.pixel_out !== exp_word.pixel ||
                   rsp_mon.frame_last !== exp_word.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: result word %0d: pixel_out expected %h got %h, ",
                               "frame_last expected %b got %b"},
                              $time, results_checked, exp_word.pixel, rsp_mon.pixel_out,
                              exp_word.last, rsp_mon.frame_last);
               end
            end
         end
      end
      words_pending <= pixel_queue.size();
   end

endmodule

// File: tb/tb_nearest_neighbor_resize.sv
`timescale 1ns / 1ps
// Top of the nearest-neighbor resizer testbench: clock, reset, register
// writes and request/response traffic; the checker judges every result word.
// Depends on nnr_pkg, nnr_if, nnr_resize_checker and the resizer RTL.

module tb_nearest_neighbor_resize;
   import nnr_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   nnr_req_if req_ch ();
   nnr_rsp_if rsp_ch ();

   bit req_gaps_on;
   bit rsp_stalls_on;
   int mismatch_count, words_pending, results_checked, frames_seen;
   int load_words, emit_words, settings_used, random_words;
   int quiet_cycles;

   nearest_neighbor_resize u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nnr_resize_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending),
      .results_checked (results_checked),
      .frames_seen     (frames_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !rsp_stalls_on || ($urandom_range(99) >= 28);
   end

   // Ends a run in which no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles.", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int eff_size(input logic [CFG_W-1:0] raw, input int hi);
      if (raw == '0) return 1;
      if (raw > hi) return hi;
      return int'(raw);
   endfunction

   function automatic int frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                     input logic [CFG_W-1:0] ch);
      return eff_size(w, DEF_MAX_DIM) * eff_size(h, DEF_MAX_DIM) *
             eff_size(CFG_W'(ch[CFG_CH_W-1:0]), DEF_MAX_CHANNELS);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Leaves valid high after acceptance so back-to-back words need no gap.
   task automatic send_word(input logic act, input logic [PIX_W-1:0] pix);
      while (req_gaps_on && $urandom_range(99) < 28) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.pixel_in <= pix;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (act == ACT_LOAD) load_words++;
      else emit_words++;
   endtask

   // Loads keep the block busy without producing a word, hence the extra cycles.
   task automatic wait_drained(input int extra);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                            input logic [CFG_W-1:0] ch, input logic [CFG_W-1:0] dw,
                            input logic [CFG_W-1:0] dh);
      wait_drained(8);
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_CHANNELS, ch);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic load_frame(input int total);
      repeat (total) send_word(ACT_LOAD, random_pixel());
   endtask

   task automatic run_fixed(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                            input logic [CFG_W-1:0] ch, input logic [CFG_W-1:0] dw,
                            input logic [CFG_W-1:0] dh, input int emits);
      configure(sw, sh, ch, dw, dh);
      load_frame(frame_size(sw, sh, ch));
      repeat (emits) send_word(ACT_EMIT, PIX_W'($urandom));
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] sw, sh, ch, dw, dh;
      int               total, dst_frame, n_mix, phase;
      bit               do_pause;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.action   <= ACT_LOAD;
      req_ch.pixel_in <= '0;
      rsp_stalls_on   <= 1'b1;
      req_gaps_on   = 1'b1;
      load_words    = 0;
      emit_words    = 0;
      settings_used = 0;
      random_words  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings give a 1x1 single-channel frame: every load wraps and
      // every result word ends a frame; the emit pixel field is ignored.
      send_word(ACT_LOAD, 16'hFFFF);
      send_word(ACT_EMIT, 16'h0000);
      send_word(ACT_LOAD, 16'h0000);
      send_word(ACT_EMIT, 16'hFFFF);
      send_word(ACT_EMIT, 16'h0000);

      // Upscale 2 to 3; the third load wraps onto the first pixel.
      configure(9'd2, 9'd1, 9'd1, 9'd3, 9'd1);
      send_word(ACT_LOAD, 16'h1234);
      send_word(ACT_LOAD, 16'hA5A5);
      send_word(ACT_LOAD, 16'h5A5A);
      repeat (4) send_word(ACT_EMIT, 16'h0000);

      // A write to an index past the register file must not restart the scan.
      wait_drained(8);
      write_csr(CSR_COUNT, 9'h155);
      csr_we <= 1'b0;
      repeat (2) send_word(ACT_EMIT, 16'hFFFF);

      // Zero in every register acts as one.
      configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
      send_word(ACT_LOAD, 16'hC3C3);
      repeat (2) send_word(ACT_EMIT, 16'h0000);

      // Largest sizes, and out-of-range values that saturate at the maximum.
      run_fixed(9'd511, 9'd1, 9'd1, 9'd2, 9'd1, 3);
      run_fixed(9'd3, 9'd2, 9'd7, 9'd2, 9'd1, 10);
      run_fixed(9'd2, 9'd2, 9'h1FC, 9'd511, 9'd1, 40);
      run_fixed(9'd2, 9'd2, 9'd1, 9'd1, 9'd511, 260);

      phase = 0;
      while (random_words < 650) begin
         // A long stretch in the middle runs with no gaps and no stalls.
         req_gaps_on   = (phase < 2 || phase > 3);
         rsp_stalls_on <= (phase < 2 || phase > 3);
         sw = CFG_W'($urandom_range(9));
         sh = CFG_W'($urandom_range(6));
         ch = CFG_W'($urandom_range(7));
         if ($urandom_range(3) == 0) ch[CFG_W-1:CFG_CH_W] = (CFG_W - CFG_CH_W)'($urandom);
         dw = CFG_W'($urandom_range(12));
         dh = CFG_W'($urandom_range(8));
         total     = frame_size(sw, sh, ch);
         dst_frame = frame_size(dw, dh, ch);
         n_mix     = $urandom_range(8, 2 * dst_frame + 8);
         if (n_mix > 160) n_mix = 160;
         do_pause  = (phase == 1) || ($urandom_range(3) == 0);
         configure(sw, sh, ch, dw, dh);
         load_frame(total);
         for (int i = 0; i < n_mix; i++) begin
            if (do_pause && i == n_mix / 2) wait_drained(0);
            if ($urandom_range(3) != 0)
               send_word(ACT_EMIT, PIX_W'($urandom));
            else
               send_word(ACT_LOAD, random_pixel());
         end
         random_words += total + n_mix;
         phase++;
      end

      rsp_stalls_on <= 1'b1;
      wait_drained(10);
      $display("Covered %0d load and %0d emit words under %0d register settings.",
               load_words, emit_words, settings_used);
      $display("Checked %0d result words, %0d of them closing a destination frame.",
               results_checked, frames_seen);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
